@@ hdl/mga_pkg.sv @@
// Package for the modularity gain argmax block: widths, configuration codes,
// item and candidate records, and the xorshift tie-break function.
// No dependencies.
package mga_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SHIFT       = FRAC_BITS + 32;
    localparam int PROD_W      = 97;
    localparam int GAIN_W      = 48;
    localparam int TERM_W      = GAIN_W + 1;
    localparam int DIFF_W      = GAIN_W + 2;
    localparam int TB_W        = 64;
    localparam int COMM_W      = 31;
    localparam int WORD_W      = 32;
    localparam int IDXSUM_W    = WORD_W + 2;
    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int OCC_W       = QCNT_W + 1;
    localparam int FRONT_STAGES = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 64;
    localparam logic [TB_W-1:0] SEED_RESET = 64'd1231245;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_TWO_TW = 1'b0,
        CFG_BASE_SEED  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] inv;
        logic [TB_W-1:0]   seed;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] edge_weight;
        logic [WORD_W-1:0] row_index;
        logic [COMM_W-1:0] community;
        logic [WORD_W-1:0] community_degree;
        logic [WORD_W-1:0] community_index;
        logic [WORD_W-1:0] column_index;
        logic [WORD_W-1:0] row_degree;
        logic              last;
    } t_item;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic [TB_W-1:0]          tiebreak;
        logic [COMM_W-1:0]        community;
        logic                     last;
    } t_cand;

    typedef struct packed {
        logic [FRONT_STAGES-1:0] stage_valid;
    } t_fstat;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_qstat;

    function automatic logic [TB_W-1:0] xorshift(input logic [TB_W-1:0] t_in);
        logic [TB_W-1:0] t;
        t = t_in;
        t = t ^ (t << 13);
        t = t ^ (t >> 7);
        t = t ^ (t << 17);
        return t;
    endfunction

endpackage

@@ hdl/mga_front.sv @@
// Front pipeline: forms the fixed-point gain and the tie-break of each candidate.
// Three register stages; depends on mga_pkg.
module mga_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  mga_pkg::t_item  i_item,
    input  mga_pkg::t_cfg   i_cfg,
    output mga_pkg::t_cand  o_cand,
    output logic            o_cand_valid,
    output mga_pkg::t_fstat o_stat
);
    import mga_pkg::*;

    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (SHIFT - 1);

    logic [FRONT_STAGES-1:0] r_valid, n_valid;

    logic [2*WORD_W-1:0] r_s1_prod;
    logic [TB_W-1:0]     r_s1_seedsum;
    logic [IDXSUM_W-1:0] r_s1_idxsum;
    logic [WORD_W-1:0]   r_s1_x;
    logic [COMM_W-1:0]   r_s1_comm;
    logic                r_s1_last;

    logic [2*WORD_W-1:0] r_s2_pl, r_s2_ph;
    logic [TB_W-1:0]     r_s2_tb;
    logic [WORD_W-1:0]   r_s2_x;
    logic [COMM_W-1:0]   r_s2_comm;
    logic                r_s2_last;

    logic [TERM_W-1:0]   r_s3_term, n_s3_term;
    logic [TB_W-1:0]     r_s3_tb;
    logic [WORD_W-1:0]   r_s3_x;
    logic [COMM_W-1:0]   r_s3_comm;
    logic                r_s3_last;

    logic [PROD_W-1:0]        w_sum, w_term_full;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [GAIN_W-1:0] w_gain;

    assign n_valid = {r_valid[FRONT_STAGES-2:0], i_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: degree product and the tie-break seed sums
        r_s1_prod    <= (2*WORD_W)'(i_item.row_degree) * (2*WORD_W)'(i_item.community_degree);
        r_s1_seedsum <= i_cfg.seed + TB_W'(i_item.community_degree >> FRAC_BITS);
        r_s1_idxsum  <= IDXSUM_W'(i_item.row_index) + IDXSUM_W'(i_item.community_index)
                      + IDXSUM_W'(i_item.column_index);
        r_s1_x       <= i_item.edge_weight;
        r_s1_comm    <= i_item.community;
        r_s1_last    <= i_item.last;
        // stage 2: product times reciprocal as two partial products, and the hashed tie-break
        r_s2_pl      <= (2*WORD_W)'(r_s1_prod[WORD_W-1:0]) * (2*WORD_W)'(i_cfg.inv);
        r_s2_ph      <= (2*WORD_W)'(r_s1_prod[2*WORD_W-1:WORD_W]) * (2*WORD_W)'(i_cfg.inv);
        r_s2_tb      <= xorshift(r_s1_seedsum + TB_W'(r_s1_idxsum));
        r_s2_x       <= r_s1_x;
        r_s2_comm    <= r_s1_comm;
        r_s2_last    <= r_s1_last;
        // stage 3: rounded and saturated penalty term
        r_s3_term    <= n_s3_term;
        r_s3_tb      <= r_s2_tb;
        r_s3_x       <= r_s2_x;
        r_s3_comm    <= r_s2_comm;
        r_s3_last    <= r_s2_last;
    end

    always_comb begin
        w_sum       = PROD_W'(r_s2_pl) + (PROD_W'(r_s2_ph) << WORD_W) + RND;
        w_term_full = w_sum >> SHIFT;
        if (|w_term_full[PROD_W-1:GAIN_W]) begin
            n_s3_term = TERM_W'(1) << GAIN_W;
        end else begin
            n_s3_term = {1'b0, w_term_full[GAIN_W-1:0]};
        end
    end

    always_comb begin
        w_diff = $signed(DIFF_W'(r_s3_x)) - $signed(DIFF_W'(r_s3_term));
        // saturate to the signed gain range
        if (w_diff[DIFF_W-1:GAIN_W-1] == '0 || w_diff[DIFF_W-1:GAIN_W-1] == '1) begin
            w_gain = w_diff[GAIN_W-1:0];
        end else if (w_diff[DIFF_W-1]) begin
            w_gain = {1'b1, {(GAIN_W-1){1'b0}}};
        end else begin
            w_gain = {1'b0, {(GAIN_W-1){1'b1}}};
        end
    end

    assign o_cand.gain        = w_gain;
    assign o_cand.tiebreak    = r_s3_tb;
    assign o_cand.community   = r_s3_comm;
    assign o_cand.last        = r_s3_last;
    assign o_cand_valid       = r_valid[FRONT_STAGES-1];
    assign o_stat.stage_valid = r_valid;

endmodule

@@ hdl/mga_queue.sv @@
// Candidate queue between the front pipeline and the reduction.
// Register file with read and write pointers; depends on mga_pkg.
module mga_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mga_pkg::t_cand  i_data,
    input  logic            i_pop,
    output mga_pkg::t_cand  o_data,
    output mga_pkg::t_qstat o_stat
);
    import mga_pkg::*;

    t_cand             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.empty = (r_count == '0);

endmodule

@@ hdl/mga_back.sv @@
// Reduction: keeps the running best candidate and loads the result register
// on the last candidate of a vertex. Depends on mga_pkg.
module mga_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mga_pkg::t_cand                      i_head,
    input  logic                                i_head_valid,
    output logic                                o_head_pop,
    input  logic                                i_res_pop,
    output logic                                o_res_valid,
    output logic [mga_pkg::COMM_W-1:0]          o_best_community,
    output logic signed [mga_pkg::GAIN_W-1:0]   o_best_gain
);
    import mga_pkg::*;

    logic                     r_have_best, n_have_best;
    logic signed [GAIN_W-1:0] r_gain;
    logic [TB_W-1:0]          r_tb;
    logic [COMM_W-1:0]        r_comm;
    logic                     r_res_valid, n_res_valid;
    logic [COMM_W-1:0]        r_res_comm;
    logic signed [GAIN_W-1:0] r_res_gain;

    logic                     w_take, w_consume, w_finish;
    logic signed [GAIN_W-1:0] w_sel_gain;
    logic [COMM_W-1:0]        w_sel_comm;

    always_comb begin
        w_take = !r_have_best || (i_head.gain > r_gain)
              || ((i_head.gain == r_gain) && (i_head.tiebreak > r_tb));
        // hold a last candidate until the result register is free
        w_consume   = i_head_valid && (!i_head.last || !r_res_valid || i_res_pop);
        w_finish    = w_consume && i_head.last;
        w_sel_gain  = w_take ? i_head.gain      : r_gain;
        w_sel_comm  = w_take ? i_head.community : r_comm;
        n_have_best = w_finish ? 1'b0 : (r_have_best || w_consume);
        n_res_valid = (r_res_valid && !i_res_pop) || w_finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_have_best <= n_have_best;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_consume && w_take) begin
            r_gain <= i_head.gain;
            r_tb   <= i_head.tiebreak;
            r_comm <= i_head.community;
        end
        if (w_finish) begin
            r_res_comm <= w_sel_comm;
            r_res_gain <= w_sel_gain;
        end
    end

    assign o_head_pop       = w_consume;
    assign o_res_valid      = r_res_valid;
    assign o_best_community = r_res_comm;
    assign o_best_gain      = r_res_gain;

endmodule

@@ hdl/modularity_gain_argmax.sv @@
// Top level of the modularity gain argmax block: configuration registers,
// queue credit, front pipeline, candidate queue and reduction.
// Depends on mga_pkg, mga_front, mga_queue and mga_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | i_edge_weight .. i_row_degree, i_last_candidate
//  result   | pop / empty        | o_best_community, o_best_gain
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// One candidate per cycle sustained while results are popped. A candidate passes
// the front pipeline (degree product, the two 32x32 partial products, the
// rounding add) and is registered in the queue; a result shows the cycle after
// the reduction takes the last candidate. Reset is synchronous: it empties
// the pipeline, queue and result register and loads the register defaults.
// full rises when queued plus in-flight candidates reach the queue depth of 8.
module modularity_gain_argmax (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [mga_pkg::WORD_W-1:0]          i_edge_weight,
    input  logic [mga_pkg::WORD_W-1:0]          i_row_index,
    input  logic [mga_pkg::COMM_W-1:0]          i_community,
    input  logic [mga_pkg::WORD_W-1:0]          i_community_degree,
    input  logic [mga_pkg::WORD_W-1:0]          i_community_index,
    input  logic [mga_pkg::WORD_W-1:0]          i_column_index,
    input  logic [mga_pkg::WORD_W-1:0]          i_row_degree,
    input  logic                                i_last_candidate,
    output logic                                empty,
    input  logic                                pop,
    output logic [mga_pkg::COMM_W-1:0]          o_best_community,
    output logic signed [mga_pkg::GAIN_W-1:0]   o_best_gain,
    input  logic                                i_cfg_we,
    input  logic [mga_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mga_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import mga_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_item  w_item;
    t_cand  w_cand, w_head;
    t_fstat w_fstat;
    t_qstat w_qstat;
    logic   w_accept, w_cand_valid, w_head_pop, w_res_valid;
    logic [OCC_W-1:0] w_inflight, w_occupancy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_INV_TWO_TW: n_cfg.inv  = i_cfg_wdata[WORD_W-1:0];
                CFG_BASE_SEED:  n_cfg.seed = i_cfg_wdata[TB_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv  <= '0;
            r_cfg.seed <= SEED_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        w_inflight = '0;
        for (int k = 0; k < FRONT_STAGES; k++) begin
            w_inflight = w_inflight + OCC_W'(w_fstat.stage_valid[k]);
        end
        w_occupancy = OCC_W'(w_qstat.count) + w_inflight;
    end

    // reserve a queue slot for every candidate in the front pipeline
    assign full     = (w_occupancy >= OCC_W'(QDEPTH));
    assign w_accept = push && !full;

    assign w_item.edge_weight      = i_edge_weight;
    assign w_item.row_index        = i_row_index;
    assign w_item.community        = i_community;
    assign w_item.community_degree = i_community_degree;
    assign w_item.community_index  = i_community_index;
    assign w_item.column_index     = i_column_index;
    assign w_item.row_degree       = i_row_degree;
    assign w_item.last             = i_last_candidate;

    mga_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_item       (w_item),
        .i_cfg        (r_cfg),
        .o_cand       (w_cand),
        .o_cand_valid (w_cand_valid),
        .o_stat       (w_fstat)
    );

    mga_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cand_valid),
        .i_data  (w_cand),
        .i_pop   (w_head_pop),
        .o_data  (w_head),
        .o_stat  (w_qstat)
    );

    mga_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_head_valid     (!w_qstat.empty),
        .o_head_pop       (w_head_pop),
        .i_res_pop        (pop),
        .o_res_valid      (w_res_valid),
        .o_best_community (o_best_community),
        .o_best_gain      (o_best_gain)
    );

    assign empty = !w_res_valid;

`ifndef SYNTH
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occupancy <= OCC_W'(QDEPTH))
        else $error("queue credit exceeded");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand_valid |-> (w_qstat.count < QCNT_W'(QDEPTH)))
        else $error("candidate written into full queue");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_fstat.stage_valid[0])
        else $error("accepted request lost at front stage");
`endif

endmodule

@@ tb/sv/modularity_gain_argmax_test.sv @@
`timescale 1ns / 100ps
// Testbench for modularity_gain_argmax: streams candidate communities, predicts
// the best community and gain per vertex and checks every result in order.
// Depends on mga_pkg and the modularity_gain_argmax RTL.
module modularity_gain_argmax_test;

    import mga_pkg::*;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int QUIET_TAIL     = 250;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam longint GAIN_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint GAIN_LO = -GAIN_HI - 64'sd1;

    typedef struct packed {
        logic [COMM_W-1:0]        community;
        logic signed [GAIN_W-1:0] gain;
    } t_best;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [WORD_W-1:0]        i_edge_weight = '0;
    logic [WORD_W-1:0]        i_row_index = '0;
    logic [COMM_W-1:0]        i_community = '0;
    logic [WORD_W-1:0]        i_community_degree = '0;
    logic [WORD_W-1:0]        i_community_index = '0;
    logic [WORD_W-1:0]        i_column_index = '0;
    logic [WORD_W-1:0]        i_row_degree = '0;
    logic                     i_last_candidate = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [COMM_W-1:0]        o_best_community;
    logic signed [GAIN_W-1:0] o_best_gain;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]    i_cfg_wdata = '0;

    // predictor copy of the registers and the running best
    logic [WORD_W-1:0]        inv_two_tw = '0;
    logic [TB_W-1:0]          seed_reg = SEED_RESET;
    logic                     have_best = 1'b0;
    logic signed [GAIN_W-1:0] run_gain = '0;
    logic [COMM_W-1:0]        run_comm = '0;
    logic [TB_W-1:0]          run_tie = '0;

    t_best best_results[$];
    t_best best_front;
    int    errors = 0;
    bit    tx_idle_en = 1'b0;
    logic  rx_idle_en = 1'b0;
    logic [7:0] hold_ticket = '0;
    logic [7:0] hold_served = '0;
    int    hold_left = 0;
    int    stall_left = 0;
    int    quiet_cycles = 0;

    modularity_gain_argmax dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_edge_weight      (i_edge_weight),
        .i_row_index        (i_row_index),
        .i_community        (i_community),
        .i_community_degree (i_community_degree),
        .i_community_index  (i_community_index),
        .i_column_index     (i_column_index),
        .i_row_degree       (i_row_degree),
        .i_last_candidate   (i_last_candidate),
        .empty              (empty),
        .pop                (pop),
        .o_best_community   (o_best_community),
        .o_best_gain        (o_best_gain),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // edge weight minus the rounded degree product times the reciprocal, saturated to 48 bits
    function automatic logic signed [GAIN_W-1:0] modularity_gain(
        input logic [WORD_W-1:0] w,
        input logic [WORD_W-1:0] cdeg,
        input logic [WORD_W-1:0] rdeg
    );
        logic [97:0] prod;
        logic [49:0] term;
        longint      diff;
        prod = {66'd0, rdeg} * {66'd0, cdeg} * {66'd0, inv_two_tw}
             + (98'd1 << (SHIFT - 1));
        prod = prod >> SHIFT;
        term = (prod > (98'd1 << GAIN_W)) ? (50'd1 << GAIN_W) : prod[49:0];
        diff = $signed({32'd0, w}) - $signed({14'd0, term});
        if (diff > GAIN_HI)
            diff = GAIN_HI;
        else if (diff < GAIN_LO)
            diff = GAIN_LO;
        return diff[GAIN_W-1:0];
    endfunction

    function automatic logic [TB_W-1:0] tiebreak_hash(input t_item it);
        logic [TB_W-1:0] h;
        h = seed_reg + {32'd0, it.community_degree >> FRAC_BITS} + {32'd0, it.row_index}
          + {32'd0, it.community_index} + {32'd0, it.column_index};
        h = h ^ (h << 13);
        h = h ^ (h >> 7);
        h = h ^ (h << 17);
        return h;
    endfunction

    task automatic fold_candidate(input t_item it);
        logic signed [GAIN_W-1:0] g;
        logic [TB_W-1:0]          h;
        g = modularity_gain(it.edge_weight, it.community_degree, it.row_degree);
        h = tiebreak_hash(it);
        if (!have_best || g > run_gain || (g == run_gain && h > run_tie)) begin
            have_best = 1'b1;
            run_gain = g;
            run_comm = it.community;
            run_tie = h;
        end
        if (it.last) begin
            best_results.push_back('{community: run_comm, gain: run_gain});
            have_best = 1'b0;
            run_gain = '0;
            run_comm = '0;
            run_tie = '0;
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return WORD_W'($urandom_range(0, 255));
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_item make_item(
        input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] rix,
        input logic [COMM_W-1:0] comm, input logic [WORD_W-1:0] cdeg,
        input logic [WORD_W-1:0] cix, input logic [WORD_W-1:0] col,
        input logic [WORD_W-1:0] rdeg, input logic last
    );
        t_item it;
        it.edge_weight = w;
        it.row_index = rix;
        it.community = comm;
        it.community_degree = cdeg;
        it.community_index = cix;
        it.column_index = col;
        it.row_degree = rdeg;
        it.last = last;
        return it;
    endfunction

    // hold the request until the block takes it, then predict
    task automatic send_candidate(input t_item it);
        push <= 1'b1;
        i_edge_weight <= it.edge_weight;
        i_row_index <= it.row_index;
        i_community <= it.community;
        i_community_degree <= it.community_degree;
        i_community_index <= it.community_index;
        i_column_index <= it.column_index;
        i_row_degree <= it.row_degree;
        i_last_candidate <= it.last;
        do @(posedge i_clk); while (full);
        fold_candidate(it);
    endtask

    task automatic maybe_gap();
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic settle_block();
        push <= 1'b0;
        while (best_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [WORD_W-1:0] inv, input logic [TB_W-1:0] seed);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_INV_TWO_TW;
        i_cfg_wdata <= {32'd0, inv};
        @(posedge i_clk);
        i_cfg_idx <= CFG_BASE_SEED;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        inv_two_tw = inv;
        seed_reg = seed;
    endtask

    // one vertex: random candidates, some equal-gain; fixed rows unless noisy
    task automatic send_vertex(input int n, input bit noisy);
        t_item it;
        t_item prev;
        logic [WORD_W-1:0] rix;
        logic [WORD_W-1:0] rdeg;
        int pick;
        rix = pick_word();
        rdeg = pick_word();
        prev = '0;
        for (int k = 0; k < n; k++) begin
            it = make_item(pick_word(), rix, COMM_W'(pick_word()), pick_word(),
                           pick_word(), pick_word(), rdeg, 1'b0);
            if (noisy) begin
                it.row_index = pick_word();
                it.row_degree = pick_word();
            end
            pick = $urandom_range(0, 7);
            if (k > 0 && pick == 0) begin
                it.edge_weight = prev.edge_weight;
                it.community_degree = prev.community_degree;
                it.row_degree = prev.row_degree;
            end else if (k > 0 && pick == 1) begin
                it = prev;
                it.community = COMM_W'(pick_word());
            end
            it.last = noisy ? ($urandom_range(0, 2) == 0) : (k == n - 1);
            send_candidate(it);
            prev = it;
            maybe_gap();
        end
    endtask

    task automatic test_reset_defaults();
        send_candidate(make_item('0, '0, '0, '0, '0, '0, '0, 1'b1));
        send_candidate(make_item('1, '1, '1, '1, '1, '1, '1, 1'b1));
        send_candidate(make_item(32'd100, 32'd9, 31'd5, 32'h0003_0000, 32'd1, 32'd2, 32'd7, 1'b0));
        send_candidate(make_item(32'd100, 32'd9, 31'd6, '1, '1, '1, 32'd7, 1'b0));
        send_candidate(make_item(32'd100, 32'd9, 31'd7, 32'h0003_0000, 32'd1, 32'd2, 32'd7, 1'b0));
        send_candidate(make_item(32'd50, 32'd9, 31'd8, 32'd0, 32'd0, 32'd0, 32'd7, 1'b1));
        settle_block();
    endtask

    task automatic test_saturation();
        set_config('1, '1);
        send_candidate(make_item('0, '1, 31'd3, '1, '1, '1, '1, 1'b1));
        // first candidate wins even when deeply negative
        send_candidate(make_item('1, 32'd4, 31'd11, '1, 32'd0, 32'd0, '1, 1'b1));
        send_candidate(make_item('1, 32'd4, 31'd12, '1, 32'd0, 32'd0, '1, 1'b0));
        send_candidate(make_item('0, 32'd4, 31'd13, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000,
                                 1'b0));
        send_candidate(make_item('0, 32'd4, 31'd14, '0, 32'd5, 32'd0, '0, 1'b1));
        settle_block();
    endtask

    task automatic test_rounding_and_ties();
        set_config(32'h0000_8000, '0);
        // exact half rounds up, just below half rounds down
        send_candidate(make_item('0, 32'd1, 31'd20, 32'h0001_0000, '0, '0, 32'h0001_0000, 1'b1));
        send_candidate(make_item('0, 32'd1, 31'd21, 32'h0000_FFFF, '0, '0, 32'h0001_0000, 1'b1));
        // equal negative gains, decided by the tie-break
        send_candidate(make_item(32'd2, 32'd8, 31'd22, '1, 32'd3, '0, '1, 1'b0));
        send_candidate(make_item(32'd2, 32'd8, 31'd23, '1, 32'd4, '1, '1, 1'b0));
        send_candidate(make_item(32'd2, 32'd8, 31'd24, '1, 32'd3, '0, '1, 1'b0));
        send_candidate(make_item(32'd1, 32'd8, 31'd25, '1, 32'd9, '0, '1, 1'b1));
        settle_block();
    endtask

    // stall the result side so the candidate queue fills and full rises
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        hold_ticket <= hold_ticket + 8'd1;
        for (int k = 0; k < 40; k++)
            send_vertex($urandom_range(1, 2), 1'b0);
        settle_block();
    endtask

    task automatic test_random_vertices();
        int sent;
        int seg_len;
        int seg_sent;
        int seg_limit;
        int n;
        logic [WORD_W-1:0] inv;
        logic [TB_W-1:0]   seed;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_block();
            case ($urandom_range(0, 3))
                0: inv = '0;
                1: inv = '1;
                default: inv = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 3))
                0: seed = '0;
                1: seed = '1;
                default: seed = {$urandom, $urandom};
            endcase
            set_config(inv, seed);
            if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                tx_idle_en = 1'b0;
                rx_idle_en <= 1'b0;
                seg_limit = RANDOM_ITEMS;
            end else begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en <= ($urandom_range(0, 3) != 0);
                // stop an idling segment where the quiet tail begins
                seg_limit = RANDOM_ITEMS - QUIET_TAIL;
            end
            seg_len = $urandom_range(80, 250);
            seg_sent = 0;
            while (seg_sent < seg_len && sent + seg_sent < seg_limit) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
                send_vertex(n, $urandom_range(0, 9) == 0);
                seg_sent += n;
            end
            sent += seg_sent;
        end
    endtask

    // result side: random stall bursts plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_served <= hold_ticket;
            hold_left <= 0;
            stall_left <= 0;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 14);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (best_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: community %0d gain %0d", $time,
                         o_best_community, o_best_gain);
            end else begin
                best_front = best_results.pop_front();
                if (o_best_community !== best_front.community) begin
                    errors++;
                    $display("%0t: best_community mismatch: expected %0d, got %0d", $time,
                             best_front.community, o_best_community);
                end
                if (o_best_gain !== best_front.gain) begin
                    errors++;
                    $display("%0t: best_gain mismatch: expected %0d, got %0d", $time,
                             best_front.gain, o_best_gain);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
            $display("modularity_gain_argmax test failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_saturation();
        test_rounding_and_ties();
        test_backpressure();
        test_random_vertices();
        settle_block();
        if (errors == 0)
            $display("modularity_gain_argmax test passed");
        else
            $display("modularity_gain_argmax test failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mga_pkg.sv
hdl/mga_front.sv
hdl/mga_queue.sv
hdl/mga_back.sv
hdl/modularity_gain_argmax.sv
tb/sv/modularity_gain_argmax_test.sv
